@@ sv/nni_pkg.sv @@
// Shared types and constants for the axis nearest-neighbour insert block.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package nni_pkg;

    localparam int MAX_POINTS_DEF = 256;
    localparam int COORD_BITS_DEF = 16;

    localparam int FIELD_W   = 16;  // width of the coordinate ports
    localparam int IDX_OUT_W = 8;   // width of the reported index fields

    localparam int NUM_DIR   = 4;
    localparam int DIR_BELOW = 0;
    localparam int DIR_ABOVE = 1;
    localparam int DIR_RIGHT = 2;
    localparam int DIR_LEFT  = 3;

    typedef struct packed {
        logic start;   // latch the new point, clear the best candidates
        logic rd;      // read the store at the scan address and advance
        logic finish;  // store the point and load the result register
    } t_ctrl_cmd;

    typedef struct packed {
        logic empty;     // no points stored
        logic full;      // store holds MAX_POINTS points
        logic last_rd;   // scan address is the last stored point
        logic out_free;  // result register can take a new beat
    } t_dp_status;

endpackage

@@ sv/nni_ctrl.sv @@
// Controller state machine for the nearest-neighbour insert.
// Depends on nni_pkg; drives the datapath through t_ctrl_cmd.
`timescale 1ns / 1ps

module nni_ctrl
    import nni_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_POST  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    // nothing to scan when empty; refuse at once when full
                    if (i_status.empty || i_status.full) begin
                        n_state = S_POST;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.rd = 1'b1;
                if (i_status.last_rd) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_POST;
            end
            S_POST: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_start_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |-> (r_state == S_IDLE))
        else $error("start issued outside idle");

    a_scan_ends_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.rd && i_status.last_rd) |=> (r_state == S_DRAIN))
        else $error("scan did not hand over to drain");

    a_finish_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> i_status.out_free)
        else $error("finish while result register blocked");

endmodule

@@ sv/nni_datapath.sv @@
// Datapath for the nearest-neighbour insert: point store, scan compare,
// best-candidate registers and result register. Depends on nni_pkg.
`timescale 1ns / 1ps

module nni_datapath
    import nni_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctrl_cmd            i_cmd,
    output t_dp_status           o_status,
    input  logic [FIELD_W-1:0]   i_x_coord,
    input  logic [FIELD_W-1:0]   i_y_coord,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [IDX_OUT_W-1:0] o_new_index,
    output logic                 o_store_full,
    output logic                 o_below_found,
    output logic [IDX_OUT_W-1:0] o_below_index,
    output logic                 o_above_found,
    output logic [IDX_OUT_W-1:0] o_above_index,
    output logic                 o_right_found,
    output logic [IDX_OUT_W-1:0] o_right_index,
    output logic                 o_left_found,
    output logic [IDX_OUT_W-1:0] o_left_index
);

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int D_W   = COORD_BITS + 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

    logic [2*COORD_BITS-1:0] mem [MAX_POINTS];
    logic [2*COORD_BITS-1:0] r_mem_q;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_addr;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_rd_idx;

    logic signed [COORD_BITS-1:0] r_px;
    logic signed [COORD_BITS-1:0] r_py;

    logic             r_found    [NUM_DIR];
    logic [IDX_W-1:0] r_best_idx [NUM_DIR];
    logic [D_W-1:0]   r_best_d   [NUM_DIR];

    logic                 r_out_valid;
    logic [IDX_OUT_W-1:0] r_new_index;
    logic                 r_store_full;
    logic                 r_o_found [NUM_DIR];
    logic [IDX_OUT_W-1:0] r_o_index [NUM_DIR];

    logic [COORD_BITS+FIELD_W-1:0] x_wide;
    logic [COORD_BITS+FIELD_W-1:0] y_wide;
    logic signed [COORD_BITS-1:0]  sx;
    logic signed [COORD_BITS-1:0]  sy;
    logic signed [D_W-1:0]         sx_e, sy_e, px_e, py_e;
    logic                          cand [NUM_DIR];
    logic [D_W-1:0]                cand_d [NUM_DIR];
    logic                          full;
    logic [IDX_W+IDX_OUT_W-1:0]    cnt_ext;
    logic [IDX_W+IDX_OUT_W-1:0]    best_ext [NUM_DIR];

    // fit the port width to the coordinate width
    assign x_wide = {{COORD_BITS{1'b0}}, i_x_coord};
    assign y_wide = {{COORD_BITS{1'b0}}, i_y_coord};

    assign full = (r_count == CNT_MAX);

    assign o_status.empty    = (r_count == '0);
    assign o_status.full     = full;
    assign o_status.last_rd  = ((r_addr + CNT_W'(1)) == r_count);
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    // point store: one read per scan cycle, one write per insert that is not refused
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_mem_q <= mem[r_addr[IDX_W-1:0]];
        end
        if (i_cmd.finish && !full) begin
            mem[r_count[IDX_W-1:0]] <= {r_px, r_py};
        end
    end

    assign sx   = $signed(r_mem_q[2*COORD_BITS-1:COORD_BITS]);
    assign sy   = $signed(r_mem_q[COORD_BITS-1:0]);
    assign sx_e = D_W'(sx);
    assign sy_e = D_W'(sy);
    assign px_e = D_W'(r_px);
    assign py_e = D_W'(r_py);

    // strict compares also drop a stored point at the identical position
    always_comb begin
        cand[DIR_BELOW]   = (sx == r_px) && (sy < r_py);
        cand[DIR_ABOVE]   = (sx == r_px) && (sy > r_py);
        cand[DIR_RIGHT]   = (sy == r_py) && (sx > r_px);
        cand[DIR_LEFT]    = (sy == r_py) && (sx < r_px);
        cand_d[DIR_BELOW] = D_W'(py_e - sy_e);
        cand_d[DIR_ABOVE] = D_W'(sy_e - py_e);
        cand_d[DIR_RIGHT] = D_W'(sx_e - px_e);
        cand_d[DIR_LEFT]  = D_W'(px_e - sx_e);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            for (int k = 0; k < NUM_DIR; k++) begin
                r_found[k] <= 1'b0;
            end
        end else begin
            r_rd_vld <= i_cmd.rd;
            if (i_cmd.start) begin
                r_addr <= '0;
                for (int k = 0; k < NUM_DIR; k++) begin
                    r_found[k] <= 1'b0;
                end
            end else if (i_cmd.rd) begin
                r_addr <= r_addr + CNT_W'(1);
            end
            if (r_rd_vld) begin
                // strict less keeps the earliest point on a tie
                for (int k = 0; k < NUM_DIR; k++) begin
                    if (cand[k] && (!r_found[k] || (cand_d[k] < r_best_d[k]))) begin
                        r_found[k] <= 1'b1;
                    end
                end
            end
            if (i_cmd.finish && !full) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_px <= $signed(x_wide[COORD_BITS-1:0]);
            r_py <= $signed(y_wide[COORD_BITS-1:0]);
            for (int k = 0; k < NUM_DIR; k++) begin
                r_best_idx[k] <= '0;
                r_best_d[k]   <= '0;
            end
        end
        if (i_cmd.rd) begin
            r_rd_idx <= r_addr[IDX_W-1:0];
        end
        if (r_rd_vld) begin
            for (int k = 0; k < NUM_DIR; k++) begin
                if (cand[k] && (!r_found[k] || (cand_d[k] < r_best_d[k]))) begin
                    r_best_idx[k] <= r_rd_idx;
                    r_best_d[k]   <= cand_d[k];
                end
            end
        end
    end

    // report the low bits of the index
    assign cnt_ext = {{IDX_OUT_W{1'b0}}, r_count[IDX_W-1:0]};
    always_comb begin
        for (int k = 0; k < NUM_DIR; k++) begin
            best_ext[k] = {{IDX_OUT_W{1'b0}}, r_best_idx[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_store_full <= full;
            r_new_index  <= full ? '0 : cnt_ext[IDX_OUT_W-1:0];
            for (int k = 0; k < NUM_DIR; k++) begin
                r_o_found[k] <= !full && r_found[k];
                r_o_index[k] <= (!full && r_found[k]) ? best_ext[k][IDX_OUT_W-1:0] : '0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_new_index   = r_new_index;
    assign o_store_full  = r_store_full;
    assign o_below_found = r_o_found[DIR_BELOW];
    assign o_below_index = r_o_index[DIR_BELOW];
    assign o_above_found = r_o_found[DIR_ABOVE];
    assign o_above_index = r_o_index[DIR_ABOVE];
    assign o_right_found = r_o_found[DIR_RIGHT];
    assign o_right_index = r_o_index[DIR_RIGHT];
    assign o_left_found  = r_o_found[DIR_LEFT];
    assign o_left_index  = r_o_index[DIR_LEFT];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("point count beyond store depth");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |-> (r_addr < r_count))
        else $error("scan read beyond stored points");

    a_count_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.finish && !full) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("count did not advance on insert");

endmodule

@@ sv/axis_nearest_neighbour_insert.sv @@
// Top level of the axis nearest-neighbour insert: ties controller and datapath.
// Depends on nni_pkg, nni_ctrl and nni_datapath.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------
//  in      | to block  | i_in_valid / o_in_stall | i_x_coord, i_y_coord
//  out     | from block| o_out_valid / i_out_stall| o_new_index, o_store_full, 4 x found/index
//
// An insert with points already stored steps through accept, one store read per stored
// point, a last compare, and store and report (held while the result register is blocked);
// the longest scan is with 255 points stored. An insert on an empty store and a refused
// insert on a full store go from accept straight to store and report.
// The single read port of the point store sets the length of the scan.
// Synchronous reset clears the count and control; the store needs no clearing.
// A stalled result holds in the output register; the next beat is accepted
// meanwhile, and its result waits until that register is free.
`timescale 1ns / 1ps

module axis_nearest_neighbour_insert
    import nni_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [FIELD_W-1:0]   i_x_coord,
    input  logic [FIELD_W-1:0]   i_y_coord,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [IDX_OUT_W-1:0] o_new_index,
    output logic                 o_store_full,
    output logic                 o_below_found,
    output logic [IDX_OUT_W-1:0] o_below_index,
    output logic                 o_above_found,
    output logic [IDX_OUT_W-1:0] o_above_index,
    output logic                 o_right_found,
    output logic [IDX_OUT_W-1:0] o_right_index,
    output logic                 o_left_found,
    output logic [IDX_OUT_W-1:0] o_left_index
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    nni_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    nni_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_new_index   (o_new_index),
        .o_store_full  (o_store_full),
        .o_below_found (o_below_found),
        .o_below_index (o_below_index),
        .o_above_found (o_above_found),
        .o_above_index (o_above_index),
        .o_right_found (o_right_found),
        .o_right_index (o_right_index),
        .o_left_found  (o_left_found),
        .o_left_index  (o_left_index)
    );

endmodule

@@ tb/axis_nearest_neighbour_insert_tb.sv @@
// Self-checking testbench for axis_nearest_neighbour_insert: directed table, then random
// points on a small grid, with random idling on both channels. Depends on nni_pkg and the RTL.
`timescale 1ns / 1ps

module axis_nearest_neighbour_insert_tb;
    import nni_pkg::*;

    localparam int RANDOM_ITEMS  = 530;
    localparam int QUIET_ITEMS   = 60;   // tail of the random part with no idling
    localparam int DRAIN_CYCLES  = 300;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int N_DIRECTED    = 22;

    typedef struct packed {
        logic [IDX_OUT_W-1:0]              new_index;
        logic                              full;
        logic [NUM_DIR-1:0]                found;
        logic [NUM_DIR-1:0][IDX_OUT_W-1:0] index;
    } t_nn_result;

    typedef struct {
        int         x;
        int         y;
        bit         typed;
        t_nn_result res;
    } t_stim_row;

    // Typed rows are the ones whose answer is plain from the positions alone.
    t_stim_row directed_rows [N_DIRECTED] = '{
        '{0,      0,      1'b1, '{new_index: 8'd0, full: 1'b0, found: 4'b0000, index: '0}},
        '{0,      0,      1'b1, '{new_index: 8'd1, full: 1'b0, found: 4'b0000, index: '0}},
        '{0,      -32768, 1'b1, '{new_index: 8'd2, full: 1'b0, found: 4'b0010, index: '0}},
        '{0,      32767,  1'b1, '{new_index: 8'd3, full: 1'b0, found: 4'b0001, index: '0}},
        '{32767,  0,      1'b1, '{new_index: 8'd4, full: 1'b0, found: 4'b1000, index: '0}},
        '{-32768, 0,      1'b1, '{new_index: 8'd5, full: 1'b0, found: 4'b0100, index: '0}},
        '{0,      5,      1'b0, '0},
        '{-32768, -32768, 1'b0, '0},
        '{32767,  32767,  1'b0, '0},
        '{32767,  -32768, 1'b0, '0},
        '{-32768, 32767,  1'b0, '0},
        '{1,      0,      1'b0, '0},
        '{-1,     0,      1'b0, '0},
        '{0,      -1,     1'b0, '0},
        '{0,      1,      1'b0, '0},
        '{1,      1,      1'b0, '0},
        '{-1,     -1,     1'b0, '0},
        '{0,      5,      1'b0, '0},
        '{-1,     5,      1'b0, '0},
        '{-32768, -1,     1'b0, '0},
        '{-21846, 21845,  1'b0, '0},
        '{21845,  -21846, 1'b0, '0}
    };

    string dir_name [NUM_DIR] = '{"below", "above", "right", "left"};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [FIELD_W-1:0]   i_x_coord;
    logic [FIELD_W-1:0]   i_y_coord;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [IDX_OUT_W-1:0] o_new_index;
    logic                 o_store_full;
    logic                 o_below_found;
    logic [IDX_OUT_W-1:0] o_below_index;
    logic                 o_above_found;
    logic [IDX_OUT_W-1:0] o_above_index;
    logic                 o_right_found;
    logic [IDX_OUT_W-1:0] o_right_index;
    logic                 o_left_found;
    logic [IDX_OUT_W-1:0] o_left_index;

    logic signed [FIELD_W-1:0] stored_x [MAX_POINTS_DEF];
    logic signed [FIELD_W-1:0] stored_y [MAX_POINTS_DEF];
    int                        stored_count;

    t_nn_result neighbour_results [$];
    t_nn_result seen;
    int         errors = 0;
    int         idle_cycles = 0;
    bit         quiet;

    axis_nearest_neighbour_insert dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_x_coord     (i_x_coord),
        .i_y_coord     (i_y_coord),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_new_index   (o_new_index),
        .o_store_full  (o_store_full),
        .o_below_found (o_below_found),
        .o_below_index (o_below_index),
        .o_above_found (o_above_found),
        .o_above_index (o_above_index),
        .o_right_found (o_right_found),
        .o_right_index (o_right_index),
        .o_left_found  (o_left_found),
        .o_left_index  (o_left_index)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always_comb begin
        seen.new_index        = o_new_index;
        seen.full             = o_store_full;
        seen.found[DIR_BELOW] = o_below_found;
        seen.found[DIR_ABOVE] = o_above_found;
        seen.found[DIR_RIGHT] = o_right_found;
        seen.found[DIR_LEFT]  = o_left_found;
        seen.index[DIR_BELOW] = o_below_index;
        seen.index[DIR_ABOVE] = o_above_index;
        seen.index[DIR_RIGHT] = o_right_index;
        seen.index[DIR_LEFT]  = o_left_index;
    end

    // Report full when the store is full; else scan the stored points, keep the nearest per direction, store the point.
    function automatic t_nn_result predict_insert(input logic signed [FIELD_W-1:0] x,
                                                  input logic signed [FIELD_W-1:0] y);
        t_nn_result  r;
        int unsigned best_d [NUM_DIR];
        int unsigned d;
        int          dir;
        int          a;
        int          b;
        r = '0;
        if (stored_count >= MAX_POINTS_DEF) begin
            r.full = 1'b1;
            return r;
        end
        for (int i = 0; i < stored_count; i++) begin
            dir = -1;
            d   = 0;
            if (stored_x[i] == x && stored_y[i] != y) begin
                a   = stored_y[i];
                b   = y;
                dir = (a < b) ? DIR_BELOW : DIR_ABOVE;
                d   = (a > b) ? a - b : b - a;
            end else if (stored_y[i] == y && stored_x[i] != x) begin
                a   = stored_x[i];
                b   = x;
                dir = (a > b) ? DIR_RIGHT : DIR_LEFT;
                d   = (a > b) ? a - b : b - a;
            end
            // strict less: the earliest point wins a tie
            if (dir >= 0 && (!r.found[dir] || d < best_d[dir])) begin
                r.found[dir] = 1'b1;
                r.index[dir] = i[IDX_OUT_W-1:0];
                best_d[dir]  = d;
            end
        end
        stored_x[stored_count] = x;
        stored_y[stored_count] = y;
        r.new_index = stored_count[IDX_OUT_W-1:0];
        stored_count++;
        return r;
    endfunction

    // Mostly a small grid so that rows and columns are shared; some extremes and noise.
    function automatic logic [FIELD_W-1:0] pick_coord();
        int v;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            v = int'($urandom_range(0, 16)) - 8;
        end else if (sel < 82) begin
            case ($urandom_range(0, 3))
                0: v = -32768;
                1: v = 32767;
                2: v = -1;
                default: v = 0;
            endcase
        end else begin
            v = $urandom;
        end
        return v[FIELD_W-1:0];
    endfunction

    task automatic send_point(input logic [FIELD_W-1:0] x, input logic [FIELD_W-1:0] y,
                              input bit typed, input t_nn_result typed_res);
        t_nn_result p;
        int         gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_x_coord  <= x;
        i_y_coord  <= y;
        do @(posedge i_clk); while (o_in_stall);
        p = predict_insert(x, y);
        neighbour_results.insert(neighbour_results.size(), typed ? typed_res : p);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic check_result(input t_nn_result want, input t_nn_result got);
        if (want.new_index !== got.new_index) begin
            $display("%0t: new_index expected %0d got %0d", $time, want.new_index,
                     got.new_index);
            errors++;
        end
        if (want.full !== got.full) begin
            $display("%0t: store_full expected %0b got %0b", $time, want.full, got.full);
            errors++;
        end
        for (int k = 0; k < NUM_DIR; k++) begin
            if (want.found[k] !== got.found[k]) begin
                $display("%0t: %s_found expected %0b got %0b", $time, dir_name[k],
                         want.found[k], got.found[k]);
                errors++;
            end
            if (want.index[k] !== got.index[k]) begin
                $display("%0t: %s_index expected %0d got %0d", $time, dir_name[k],
                         want.index[k], got.index[k]);
                errors++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (neighbour_results.size() == 0) begin
                $display("%0t: unexpected result beat, new_index %0d", $time, o_new_index);
                errors++;
            end else begin
                check_result(neighbour_results.pop_front(), seen);
            end
        end
    end

    // Receiver: stall in bursts, with free stretches between them.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (quiet) begin
                i_out_stall <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 16) - 1) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 64) - 1) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_x_coord    = '0;
        i_y_coord    = '0;
        stored_count = 0;
        quiet        = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIRECTED; r++) begin
            send_point(directed_rows[r].x[FIELD_W-1:0], directed_rows[r].y[FIELD_W-1:0],
                       directed_rows[r].typed, directed_rows[r].res);
        end

        // Fill the store, then keep going so that refused beats follow.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            send_point(pick_coord(), pick_coord(), 1'b0, '0);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (neighbour_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
